[sv/cht_pkg.sv]
package cht_pkg;

  // Fixed field widths of the item and result.
  localparam int KEY_BYTES  = 15;
  localparam int KEY_HI_W   = 56;
  localparam int KEY_LO_W   = 64;
  localparam int KEY_W      = KEY_HI_W + KEY_LO_W;
  localparam int SUM_W      = 12;
  localparam int POS_OUT_W  = 3;
  localparam int BKT_OUT_W  = 4;

  // Default table geometry.
  localparam int DEF_BUCKETS     = 11;
  localparam int DEF_CHAIN_DEPTH = 8;

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } cht_status_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_CMP  = 1'b1
  } cht_bstate_t;

  typedef struct packed {
    logic                cmd;
    logic [KEY_HI_W-1:0] key_high;
    logic [KEY_LO_W-1:0] key_low;
  } cht_req_t;

  typedef struct packed {
    cht_status_t          status;
    logic [POS_OUT_W-1:0] position;
    logic [BKT_OUT_W-1:0] bucket;
  } cht_result_t;

  // Unsigned sum of the fifteen key bytes.
  function automatic logic [SUM_W-1:0] key_byte_sum(input logic [KEY_W-1:0] key);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      acc = acc + SUM_W'(key[i*8 +: 8]);
    end
    return acc;
  endfunction

endpackage

[sv/cht_ram.sv]
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/cht_fifo.sv]
module cht_fifo import cht_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           empty,
  output logic [$clog2(DEPTH + 1)-1:0]   level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] level_r, level_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    level_nxt = level_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rptr_r];
  assign empty = (level_r == '0);
  assign level = level_r;

endmodule

[sv/cht_front.sv]
module cht_front import cht_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  cht_req_t                   req,
  input  logic [LVL_W-1:0]           fifo_level,
  output logic                       busy,
  output logic                       push,
  output cht_req_t                   push_req,
  output logic [$clog2(BUCKETS)-1:0] push_bucket
);

  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int RECIP_SH = 24;
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((1 << RECIP_SH) / BUCKETS);
  localparam int PROD_W   = SUM_W + RECIP_SH;
  localparam int QB_W     = SUM_W + 7;
  localparam int OCC_W    = LVL_W + 2;

  logic             v1_r, v2_r, v3_r;
  cht_req_t         req1_r, req2_r, req3_r;
  logic [SUM_W-1:0] sum1_r, sum2_r;
  logic [SUM_W-1:0] q2_r;
  logic [BKT_W-1:0] bkt3_r;

  logic              accept;
  logic [PROD_W-1:0] prod;
  logic [QB_W-1:0]   qb;
  logic [QB_W-1:0]   rem_w;
  logic [7:0]        rem8;
  logic [7:0]        rem_fix;
  logic [OCC_W-1:0]  occupancy;

  // Items in flight plus items queued; new items wait once the queue
  // could not take everything already in the pipeline.
  assign occupancy = OCC_W'(fifo_level) + OCC_W'(v1_r) + OCC_W'(v2_r) + OCC_W'(v3_r);
  assign busy      = (occupancy >= OCC_W'(QUEUE_DEPTH));
  assign accept    = start && !busy;

  // Quotient estimate by reciprocal; it is low by at most one.
  assign prod = PROD_W'(sum1_r) * PROD_W'(RECIP);

  always_comb begin
    qb      = QB_W'(q2_r) * QB_W'(BUCKETS);
    rem_w   = QB_W'(sum2_r) - qb;
    rem8    = rem_w[7:0];
    rem_fix = (rem8 >= 8'(BUCKETS)) ? rem8 - 8'(BUCKETS) : rem8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    req1_r <= req;
    sum1_r <= key_byte_sum({req.key_high, req.key_low});
    req2_r <= req1_r;
    sum2_r <= sum1_r;
    q2_r   <= prod[PROD_W-1:RECIP_SH];
    req3_r <= req2_r;
    bkt3_r <= BKT_W'(rem_fix);
  end

  assign push        = v3_r;
  assign push_req    = req3_r;
  assign push_bucket = bkt3_r;

endmodule

[sv/cht_back.sv]
module cht_back import cht_pkg::*; #(
  parameter int BUCKETS     = DEF_BUCKETS,
  parameter int CHAIN_DEPTH = DEF_CHAIN_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fifo_empty,
  input  cht_req_t                   head_req,
  input  logic [$clog2(BUCKETS)-1:0] head_bucket,
  output logic                       pop,
  output logic                       res_valid,
  output cht_result_t                res
);

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int CNT_W  = $clog2(CHAIN_DEPTH + 1);
  localparam int SLOT_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int ROW_W  = KEY_W * CHAIN_DEPTH;

  cht_bstate_t      state_r, state_nxt;
  cht_req_t         req_r;
  logic [BKT_W-1:0] bkt_r;
  logic [CNT_W-1:0] counts_r [BUCKETS];
  logic             res_valid_r, res_valid_nxt;
  cht_result_t      res_r, res_nxt;

  logic [ROW_W-1:0]       row_rd;
  logic [ROW_W-1:0]       row_wr;
  logic                   row_we;
  logic [CNT_W-1:0]       n;
  logic                   full;
  logic [KEY_W-1:0]       key;
  logic [CHAIN_DEPTH-1:0] hit;
  logic [SLOT_W-1:0]      hit_idx;
  logic                   any_hit;
  logic [CNT_W-1:0]       pos;
  logic [6:0]             pos_wide;
  logic [6:0]             bkt_wide;

  cht_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BUCKETS)
  ) u_rows (
    .clk  (clk),
    .we   (row_we),
    .waddr(bkt_r),
    .wdata(row_wr),
    .raddr(head_bucket),
    .rdata(row_rd)
  );

  assign key  = {req_r.key_high, req_r.key_low};
  assign n    = counts_r[bkt_r];
  assign full = (n == CNT_W'(CHAIN_DEPTH));

  // Compare every live slot of the row at once; the newest live slot is
  // the chain head, so the highest matching slot wins.
  always_comb begin
    hit_idx = '0;
    any_hit = 1'b0;
    for (int i = 0; i < CHAIN_DEPTH; i++) begin
      hit[i] = (CNT_W'(i) < n) && (row_rd[i*KEY_W +: KEY_W] == key);
      if (hit[i]) begin
        hit_idx = SLOT_W'(i);
        any_hit = 1'b1;
      end
    end
    pos      = n - 1'b1 - CNT_W'(hit_idx);
    pos_wide = 7'(pos);
    bkt_wide = 7'(bkt_r);
  end

  always_comb begin
    for (int i = 0; i < CHAIN_DEPTH; i++) begin
      row_wr[i*KEY_W +: KEY_W] = (CNT_W'(i) == n) ? key : row_rd[i*KEY_W +: KEY_W];
    end
  end

  // Next state.
  always_comb begin
    case (state_r)
      B_IDLE:  state_nxt = fifo_empty ? B_IDLE : B_CMP;
      B_CMP:   state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    pop            = 1'b0;
    row_we         = 1'b0;
    res_valid_nxt  = 1'b0;
    res_nxt        = res_r;
    case (state_r)
      B_IDLE: begin
        pop = !fifo_empty;
      end
      B_CMP: begin
        res_valid_nxt = 1'b1;
        res_nxt.bucket   = bkt_wide[BKT_OUT_W-1:0];
        res_nxt.position = '0;
        if (req_r.cmd == CMD_INSERT) begin
          if (full) begin
            res_nxt.status = ST_FULL;
          end else begin
            res_nxt.status = ST_INSERTED;
            row_we         = 1'b1;
          end
        end else if (any_hit) begin
          res_nxt.status   = ST_FOUND;
          res_nxt.position = pos_wide[POS_OUT_W-1:0];
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      res_valid_r <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      if (row_we) begin
        counts_r[bkt_r] <= n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (pop) begin
      req_r <= head_req;
      bkt_r <= head_bucket;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

[sv/chained_hash_table_insert_search_core.sv]
// Path: with the back end idle, an item accepted by start passes the three front
// stages, one queue slot and one row compare before out_valid rises.
// The back end takes a new item only after finishing the read-modify-write of one
// bucket row in the row RAM. busy rises while queue and front hold four items.
// Reset (rst_n low, synchronous) empties the queue, zeroes all chain counts and
// drops any pending result; the key store itself is not cleared.
module chained_hash_table_insert_search_core import cht_pkg::*; #(
  parameter int BUCKETS     = DEF_BUCKETS,
  parameter int CHAIN_DEPTH = DEF_CHAIN_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [KEY_HI_W-1:0]  in_key_high,
  input  logic [KEY_LO_W-1:0]  in_key_low,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [POS_OUT_W-1:0] out_position,
  output logic [BKT_OUT_W-1:0] out_bucket
);

  localparam int BKT_W = $clog2(BUCKETS);
  localparam int ENT_W = $bits(cht_req_t) + BKT_W;

  cht_req_t         in_req;
  cht_req_t         push_req;
  logic [BKT_W-1:0] push_bucket;
  logic             fifo_push;
  logic             fifo_pop;
  logic             fifo_empty;
  logic [LVL_W-1:0] fifo_level;
  logic [ENT_W-1:0] fifo_rdata;
  cht_req_t         head_req;
  logic [BKT_W-1:0] head_bucket;
  cht_result_t      res;

  // The item as presented on the input ports.
  assign in_req.cmd      = in_command;
  assign in_req.key_high = in_key_high;
  assign in_req.key_low  = in_key_low;

  // Front end: takes items, sums the key bytes and reduces the sum to a
  // bucket index over three pipeline stages.
  cht_front #(
    .BUCKETS(BUCKETS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req        (in_req),
    .fifo_level (fifo_level),
    .busy       (busy),
    .push       (fifo_push),
    .push_req   (push_req),
    .push_bucket(push_bucket)
  );

  // Short queue that lets the front keep taking items while the back end
  // works through a bucket row.
  cht_fifo #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fifo_push),
    .wdata({push_req, push_bucket}),
    .pop  (fifo_pop),
    .rdata(fifo_rdata),
    .empty(fifo_empty),
    .level(fifo_level)
  );

  assign head_req    = fifo_rdata[ENT_W-1:BKT_W];
  assign head_bucket = fifo_rdata[BKT_W-1:0];

  // Back end: reads the bucket row, compares every chain entry in parallel,
  // writes the row back on an insert and registers the result.
  cht_back #(
    .BUCKETS    (BUCKETS),
    .CHAIN_DEPTH(CHAIN_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head_req   (head_req),
    .head_bucket(head_bucket),
    .pop        (fifo_pop),
    .res_valid  (out_valid),
    .res        (res)
  );

  assign out_status   = res.status;
  assign out_position = res.position;
  assign out_bucket   = res.bucket;

  // The back end returns to idle after every item, so results never come back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe high in two consecutive cycles");

  // The busy accounting must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> (fifo_level < LVL_W'(QUEUE_DEPTH)))
    else $error("queue push while full");

  // The back end only takes an item that is there.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty)
    else $error("queue pop while empty");

endmodule
